>>> rtl/gmc_pkg.sv
// Package: gate motor controller types, codes and defaults.
package gmc_pkg;

  localparam int unsigned ElapsedBitsDef = 16;
  localparam int unsigned OpW            = 3;
  localparam int unsigned StateW         = 3;
  localparam int unsigned DutyW          = 7;
  localparam int unsigned LimitW         = 16;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 16;

  // event codes
  localparam logic [OpW-1:0] OP_TICK        = 3'd0;
  localparam logic [OpW-1:0] OP_OPEN_LIMIT  = 3'd1;
  localparam logic [OpW-1:0] OP_CLOSE_LIMIT = 3'd2;
  localparam logic [OpW-1:0] OP_STOP        = 3'd3;
  localparam logic [OpW-1:0] OP_OPEN_CMD    = 3'd4;
  localparam logic [OpW-1:0] OP_CLOSE_CMD   = 3'd5;

  // gate states
  localparam logic [StateW-1:0] GS_CLOSED  = 3'd0;
  localparam logic [StateW-1:0] GS_OPENING = 3'd1;
  localparam logic [StateW-1:0] GS_OPENED  = 3'd2;
  localparam logic [StateW-1:0] GS_CLOSING = 3'd3;
  localparam logic [StateW-1:0] GS_STOPPED = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MIN_DUTY    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DUTY    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT_TICKS = 2'd2;

  localparam logic [DutyW-1:0]  DUTY_CAP        = 7'd100;
  localparam logic [DutyW-1:0]  MIN_DUTY_RST    = 7'd30;
  localparam logic [DutyW-1:0]  MAX_DUTY_RST    = 7'd100;
  localparam logic [LimitW-1:0] LIMIT_TICKS_RST = 16'd300;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           level_ok;
    logic           open_limit_pressed;
    logic           close_limit_pressed;
  } gmc_item_t;

  typedef struct packed {
    logic [DutyW-1:0]  min_duty;
    logic [DutyW-1:0]  max_duty;
    logic [LimitW-1:0] limit_ticks;
  } gmc_cfg_t;

  typedef struct packed {
    logic [StateW-1:0] door_state;
    logic              motor_enable;
    logic              drive_a;
    logic              drive_b;
    logic [DutyW-1:0]  duty;
    logic              timed_out;
  } gmc_res_t;

endpackage

>>> rtl/gmc_if.sv
// Interfaces: event request channel and result channel.
interface gmc_in_if
  import gmc_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [OpW-1:0] op;
  logic           level_ok;
  logic           open_limit_pressed;
  logic           close_limit_pressed;

  modport source (output valid, output op, output level_ok, output open_limit_pressed,
                  output close_limit_pressed, input ready);
  modport sink   (input valid, input op, input level_ok, input open_limit_pressed,
                  input close_limit_pressed, output ready);
endinterface

interface gmc_out_if
  import gmc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [StateW-1:0] door_state;
  logic              motor_enable;
  logic              drive_a;
  logic              drive_b;
  logic [DutyW-1:0]  duty;
  logic              timed_out;

  modport source (output valid, output door_state, output motor_enable, output drive_a,
                  output drive_b, output duty, output timed_out, input ready);
  modport sink   (input valid, input door_state, input motor_enable, input drive_a,
                  input drive_b, input duty, input timed_out, output ready);
endinterface

>>> rtl/gate_motor_controller.sv
// Top level: gate motor controller with input register, sequencer and result register.
//
// Channel   Dir  Payload
// in_if     in   op, level_ok, open_limit_pressed, close_limit_pressed
// out_if    out  door_state, motor_enable, drive_a, drive_b, duty, timed_out
// cfg       in   cfg_we_i, cfg_idx_i (0 min_duty, 1 max_duty, 2 limit_ticks), cfg_data_i
//
// One request per clock unless the result stalls; each request goes into the input register,
// and the state update runs combinationally from there into the result register.
// Reset clears the sequencer to STOPPED and loads the register defaults.
// A stalled result holds; the input register takes one more request meanwhile.
module gate_motor_controller
  import gmc_pkg::*;
#(
  parameter int unsigned ELAPSED_BITS = ElapsedBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  gmc_in_if.sink              in_if,
  gmc_out_if.source           out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  gmc_cfg_t  cfg_q;
  gmc_item_t item_q;
  logic      item_v_q;
  gmc_res_t  res_d, res_q;
  logic      res_v_q;
  logic      advance, step_en, in_acc;

  assign advance     = !res_v_q || out_if.ready;
  assign step_en     = item_v_q && advance;
  assign in_if.ready = !item_v_q || advance;
  assign in_acc      = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_duty    <= MIN_DUTY_RST;
      cfg_q.max_duty    <= MAX_DUTY_RST;
      cfg_q.limit_ticks <= LIMIT_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_DUTY:    cfg_q.min_duty    <= cfg_data_i[DutyW-1:0];
        CFG_MAX_DUTY:    cfg_q.max_duty    <= cfg_data_i[DutyW-1:0];
        CFG_LIMIT_TICKS: cfg_q.limit_ticks <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        item_v_q <= 1'b1;
      end else if (advance) begin
        item_v_q <= 1'b0;
      end
      if (advance) res_v_q <= item_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.op                  <= in_if.op;
      item_q.level_ok            <= in_if.level_ok;
      item_q.open_limit_pressed  <= in_if.open_limit_pressed;
      item_q.close_limit_pressed <= in_if.close_limit_pressed;
    end
    if (step_en) res_q <= res_d;
  end

  gmc_core #(
    .ELAPSED_BITS(ELAPSED_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_en_i(step_en),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .res_o    (res_d)
  );

  assign out_if.valid        = res_v_q;
  assign out_if.door_state   = res_q.door_state;
  assign out_if.motor_enable = res_q.motor_enable;
  assign out_if.drive_a      = res_q.drive_a;
  assign out_if.drive_b      = res_q.drive_b;
  assign out_if.duty         = res_q.duty;
  assign out_if.timed_out    = res_q.timed_out;

`ifndef SYNTH
  a_drive_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.motor_enable |-> (out_if.drive_a ^ out_if.drive_b))
    else $error("moving result without exactly one drive direction");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.motor_enable |->
      (out_if.duty == '0) && !out_if.drive_a && !out_if.drive_b)
    else $error("idle result with drive or duty");

  a_timeout_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.timed_out |->
      (out_if.door_state == GS_STOPPED) && !out_if.motor_enable)
    else $error("timeout without stopped state");

  a_item_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_v_q && !advance |=> item_v_q && $stable(item_q))
    else $error("pending request lost while result stalled");
`endif

endmodule

>>> rtl/gmc_core.sv
// Gate sequencer state registers and combinational event update.
module gmc_core
  import gmc_pkg::*;
#(
  parameter int unsigned ELAPSED_BITS = ElapsedBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_en_i,
  input  gmc_item_t item_i,
  input  gmc_cfg_t  cfg_i,
  output gmc_res_t  res_o
);

  localparam int unsigned CmpW = (ELAPSED_BITS > LimitW) ? ELAPSED_BITS : LimitW;

  logic [StateW-1:0]       mode_q, mode_d;
  logic                    sreq_q, sreq_d;
  logic                    mv_q, mv_d;
  logic                    mvo_q, mvo_d;
  logic [DutyW-1:0]        duty_q, duty_d;
  logic [ELAPSED_BITS-1:0] el_q, el_d;
  logic                    timeout;
  logic                    want_open;
  logic [DutyW-1:0]        cmin, cmax;

  always_comb begin
    cmin      = (cfg_i.min_duty > DUTY_CAP) ? DUTY_CAP : cfg_i.min_duty;
    cmax      = (cfg_i.max_duty > DUTY_CAP) ? DUTY_CAP : cfg_i.max_duty;
    mode_d    = mode_q;
    sreq_d    = sreq_q;
    mv_d      = mv_q;
    mvo_d     = mvo_q;
    duty_d    = duty_q;
    el_d      = el_q;
    timeout   = 1'b0;
    want_open = 1'b0;

    if (item_i.op == OP_TICK) begin
      if (mv_q) begin
        if (duty_q < cmax) duty_d = duty_q + 1'b1;
        if (!(&el_q)) el_d = el_q + 1'b1;
        timeout = CmpW'(el_d) > CmpW'(cfg_i.limit_ticks);
        if (sreq_q || timeout) begin
          mv_d   = 1'b0;
          mvo_d  = 1'b0;
          sreq_d = 1'b0;
          if (timeout) mode_d = GS_STOPPED;
        end
      end
    end else if (item_i.level_ok) begin
      unique case (item_i.op)
        OP_OPEN_LIMIT: begin
          sreq_d = 1'b1;
          mode_d = GS_OPENED;
        end
        OP_CLOSE_LIMIT: begin
          sreq_d = 1'b1;
          mode_d = GS_CLOSED;
        end
        OP_STOP: begin
          sreq_d = 1'b1;
          if (mode_q != GS_OPENED && mode_q != GS_CLOSED) mode_d = GS_STOPPED;
        end
        OP_OPEN_CMD: begin
          if (mode_q == GS_CLOSING) sreq_d = 1'b1;
          mode_d = GS_OPENING;
        end
        OP_CLOSE_CMD: begin
          if (mode_q == GS_OPENING) sreq_d = 1'b1;
          mode_d = GS_CLOSING;
        end
        default: ;
      endcase
    end

    // start motion from an idle opening/closing state
    if (!mv_d && (mode_d == GS_OPENING || mode_d == GS_CLOSING)) begin
      want_open = (mode_d == GS_OPENING);
      if (want_open && item_i.open_limit_pressed) begin
        mode_d = GS_OPENED;
      end else if (!want_open && item_i.close_limit_pressed) begin
        mode_d = GS_CLOSED;
      end else begin
        mv_d   = 1'b1;
        mvo_d  = want_open;
        sreq_d = 1'b0;
        el_d   = '0;
        duty_d = (cmin < cmax) ? cmin + 1'b1 : cmin;
      end
    end
  end

  always_comb begin
    res_o.door_state   = mode_d;
    res_o.motor_enable = mv_d;
    res_o.drive_a      = mv_d && !mvo_d;
    res_o.drive_b      = mv_d && mvo_d;
    res_o.duty         = mv_d ? duty_d : '0;
    res_o.timed_out    = timeout;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= GS_STOPPED;
      sreq_q <= 1'b0;
      mv_q   <= 1'b0;
      mvo_q  <= 1'b0;
      duty_q <= '0;
      el_q   <= '0;
    end else if (step_en_i) begin
      mode_q <= mode_d;
      sreq_q <= sreq_d;
      mv_q   <= mv_d;
      mvo_q  <= mvo_d;
      duty_q <= duty_d;
      el_q   <= el_d;
    end
  end

endmodule

>>> tb/sv/tb.sv
// Testbench for gate_motor_controller: directed and random events checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gmc_pkg::*;

  localparam int unsigned ElapsedW = ElapsedBitsDef;

  // Tracks the gate sequencer and holds the results it still owes.
  class gate_result_board;
    logic [DutyW-1:0]    min_duty;
    logic [DutyW-1:0]    max_duty;
    logic [LimitW-1:0]   limit_ticks;
    logic [StateW-1:0]   gate_mode;
    logic                stop_req;
    logic                moving;
    logic                moving_open;
    logic [DutyW-1:0]    duty_now;
    logic [ElapsedW-1:0] elapsed;
    gmc_res_t            due_results[$];
    int                  mismatches;
    int                  results_checked;
    int                  timeouts_due;

    function new();
      min_duty        = MIN_DUTY_RST;
      max_duty        = MAX_DUTY_RST;
      limit_ticks     = LIMIT_TICKS_RST;
      gate_mode       = GS_STOPPED;
      stop_req        = 1'b0;
      moving          = 1'b0;
      moving_open     = 1'b0;
      duty_now        = '0;
      elapsed         = '0;
      mismatches      = 0;
      results_checked = 0;
      timeouts_due    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_MIN_DUTY:    min_duty = val[DutyW-1:0];
        CFG_MAX_DUTY:    max_duty = val[DutyW-1:0];
        CFG_LIMIT_TICKS: limit_ticks = val[LimitW-1:0];
        default: ;
      endcase
    endfunction

    function logic [DutyW-1:0] clip(logic [DutyW-1:0] v);
      return (v > DUTY_CAP) ? DUTY_CAP : v;
    endfunction

    // Idle gate with a pending direction either starts or lands on the pressed limit.
    function void launch_motor(logic open_pr, logic close_pr);
      logic want_open;
      if (moving) return;
      if (gate_mode == GS_OPENING) want_open = 1'b1;
      else if (gate_mode == GS_CLOSING) want_open = 1'b0;
      else return;
      if (want_open && open_pr) begin
        gate_mode = GS_OPENED;
        return;
      end
      if (!want_open && close_pr) begin
        gate_mode = GS_CLOSED;
        return;
      end
      moving      = 1'b1;
      moving_open = want_open;
      stop_req    = 1'b0;
      elapsed     = '0;
      duty_now    = clip(min_duty);
      if (duty_now < clip(max_duty)) duty_now = duty_now + 1'b1;
    endfunction

    function void note_request(gmc_item_t it);
      logic     tmo;
      gmc_res_t r;
      tmo = 1'b0;
      if (it.op == OP_TICK) begin
        if (moving) begin
          if (duty_now < clip(max_duty)) duty_now = duty_now + 1'b1;
          if (elapsed != '1) elapsed = elapsed + 1'b1;
          tmo = (elapsed > limit_ticks);
          if (stop_req || tmo) begin
            moving      = 1'b0;
            moving_open = 1'b0;
            stop_req    = 1'b0;
            if (tmo) gate_mode = GS_STOPPED;
          end
        end
      end else if (it.level_ok) begin
        case (it.op)
          OP_OPEN_LIMIT: begin
            stop_req  = 1'b1;
            gate_mode = GS_OPENED;
          end
          OP_CLOSE_LIMIT: begin
            stop_req  = 1'b1;
            gate_mode = GS_CLOSED;
          end
          OP_STOP: begin
            stop_req = 1'b1;
            if (gate_mode != GS_OPENED && gate_mode != GS_CLOSED) gate_mode = GS_STOPPED;
          end
          OP_OPEN_CMD: begin
            if (gate_mode == GS_CLOSING) stop_req = 1'b1;
            gate_mode = GS_OPENING;
          end
          OP_CLOSE_CMD: begin
            if (gate_mode == GS_OPENING) stop_req = 1'b1;
            gate_mode = GS_CLOSING;
          end
          default: ;
        endcase
      end
      launch_motor(it.open_limit_pressed, it.close_limit_pressed);
      r.door_state   = gate_mode;
      r.motor_enable = moving;
      r.drive_a      = moving && !moving_open;
      r.drive_b      = moving && moving_open;
      r.duty         = moving ? duty_now : '0;
      r.timed_out    = tmo;
      if (tmo) timeouts_due++;
      due_results.push_back(r);
    endfunction

    function void check_result(gmc_res_t got);
      gmc_res_t exp;
      logic     bad;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none expected: gs=%0d en=%0b a=%0b b=%0b duty=%0d to=%0b",
                   $time, got.door_state, got.motor_enable, got.drive_a, got.drive_b,
                   got.duty, got.timed_out);
        return;
      end
      exp = due_results.pop_front();
      results_checked++;
      bad = (got.door_state !== exp.door_state) || (got.motor_enable !== exp.motor_enable) ||
            (got.drive_a !== exp.drive_a) || (got.drive_b !== exp.drive_b) ||
            (got.duty !== exp.duty) || (got.timed_out !== exp.timed_out);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch on result %0d", $time, results_checked);
          $display("  exp gs=%0d en=%0b a=%0b b=%0b duty=%0d to=%0b", exp.door_state,
                   exp.motor_enable, exp.drive_a, exp.drive_b, exp.duty, exp.timed_out);
          $display("  got gs=%0d en=%0b a=%0b b=%0b duty=%0d to=%0b", got.door_state,
                   got.motor_enable, got.drive_a, got.drive_b, got.duty, got.timed_out);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  gmc_in_if  in_if ();
  gmc_out_if out_if ();

  gate_motor_controller dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  gate_result_board sb = new();

  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_left;
  logic recv_hold;
  int   live_requests;
  int   accepted;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // long receiver hold-off, counted here
  initial begin
    recv_hold = 1'b0;
    forever begin
      @(posedge clk);
      recv_hold = (hold_left > 0);
      if (hold_left > 0) hold_left--;
    end
  end

  initial begin
    gmc_res_t got;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.door_state   = out_if.door_state;
        got.motor_enable = out_if.motor_enable;
        got.drive_a      = out_if.drive_a;
        got.drive_b      = out_if.drive_b;
        got.duty         = out_if.duty;
        got.timed_out    = out_if.timed_out;
        sb.check_result(got);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL gate_motor_controller");
    $finish;
  end

  // Called and left at a falling edge; valid stays high after the request.
  task automatic send_item(input gmc_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid               = 1'b0;
      in_if.op                  = OpW'($urandom_range(7));
      in_if.level_ok            = 1'($urandom_range(1));
      in_if.open_limit_pressed  = 1'($urandom_range(1));
      in_if.close_limit_pressed = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_if.valid               = 1'b1;
    in_if.op                  = it.op;
    in_if.level_ok            = it.level_ok;
    in_if.open_limit_pressed  = it.open_limit_pressed;
    in_if.close_limit_pressed = it.close_limit_pressed;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(it);
    accepted++;
    if (it.op <= OP_CLOSE_CMD && (it.op == OP_TICK || it.level_ok)) live_requests++;
    @(negedge clk);
  endtask

  task automatic send_ev(input logic [OpW-1:0] op, input logic lvl, input logic opr,
                         input logic cpr);
    gmc_item_t it;
    it.op                  = op;
    it.level_ok            = lvl;
    it.open_limit_pressed  = opr;
    it.close_limit_pressed = cpr;
    send_item(it);
  endtask

  function automatic logic rare_press();
    return ($urandom_range(9) == 0);
  endfunction

  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic configure(input int mn, input int mx, input int lim);
    drain();
    repeat (4) @(negedge clk);
    write_reg(CFG_MIN_DUTY, CfgDataW'(mn));
    write_reg(CFG_MAX_DUTY, CfgDataW'(mx));
    write_reg(CFG_LIMIT_TICKS, CfgDataW'(lim));
  endtask

  // command, a run of ticks with stray events, an ending event, then ticks
  task automatic run_motion();
    logic          dir;
    int            nt;
    int            long_cap;
    logic [OpW-1:0] ev;
    dir      = 1'($urandom_range(1));
    long_cap = (sb.limit_ticks > 310) ? 310 : int'(sb.limit_ticks) + 3;
    send_ev(dir ? OP_OPEN_CMD : OP_CLOSE_CMD, 1'b1, rare_press(), rare_press());
    nt = ($urandom_range(7) == 0) ? $urandom_range(long_cap) : $urandom_range(12);
    for (int i = 0; i < nt; i++) begin
      if ($urandom_range(9) != 0) ev = OP_TICK;
      else ev = OpW'($urandom_range(OP_CLOSE_CMD, OP_OPEN_LIMIT));
      send_ev(ev, ($urandom_range(4) != 0), rare_press(), rare_press());
    end
    case ($urandom_range(3))
      0: ev = dir ? OP_OPEN_LIMIT : OP_CLOSE_LIMIT;
      1: ev = OP_STOP;
      2: ev = dir ? OP_CLOSE_CMD : OP_OPEN_CMD;
      default: ev = OP_TICK;
    endcase
    send_ev(ev, ($urandom_range(9) != 0), rare_press(), rare_press());
    repeat ($urandom_range(1, 2)) send_ev(OP_TICK, 1'($urandom_range(1)), rare_press(),
                                           rare_press());
  endtask

  task automatic run_traffic(input int budget);
    int stop_at;
    stop_at = live_requests + budget;
    while (live_requests < stop_at) begin
      if ($urandom_range(99) < 75) run_motion();
      else send_ev(OpW'($urandom_range(7)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
    end
  endtask

  // receiver holds off while requests keep coming, then the sender waits for all results and sends more
  task automatic run_phase(input int budget);
    run_traffic(budget / 2);
    hold_left = 80;
    run_traffic(budget / 4);
    drain();
    run_traffic(budget / 4);
  endtask

  task automatic run_directed();
    send_ev(OP_TICK, 1'b1, 1'b0, 1'b0);         // tick while idle
    send_ev(3'd6, 1'b1, 1'b1, 1'b0);            // unused codes
    send_ev(3'd7, 1'b1, 1'b1, 1'b1);
    send_ev(OP_STOP, 1'b0, 1'b0, 1'b0);         // pin no longer active
    send_ev(OP_OPEN_CMD, 1'b0, 1'b0, 1'b1);
    send_ev(OP_STOP, 1'b1, 1'b0, 1'b0);         // stale stop request
    send_ev(OP_OPEN_CMD, 1'b1, 1'b1, 1'b0);     // start blocked by open limit
    send_ev(OP_STOP, 1'b1, 1'b0, 1'b0);         // stop keeps OPENED
    send_ev(OP_CLOSE_CMD, 1'b1, 1'b0, 1'b0);
    send_ev(OP_TICK, 1'b0, 1'b1, 1'b1);
    send_ev(OP_TICK, 1'b1, 1'b0, 1'b0);
    send_ev(OP_OPEN_CMD, 1'b1, 1'b0, 1'b0);     // reversal while moving
    send_ev(OP_TICK, 1'b1, 1'b0, 1'b0);
    send_ev(OP_TICK, 1'b1, 1'b0, 1'b0);
    send_ev(OP_OPEN_LIMIT, 1'b1, 1'b1, 1'b0);
    send_ev(OP_TICK, 1'b1, 1'b1, 1'b0);
    send_ev(OP_CLOSE_CMD, 1'b1, 1'b0, 1'b1);    // start blocked by close limit
    send_ev(OP_OPEN_CMD, 1'b1, 1'b0, 1'b0);
    send_ev(OP_TICK, 1'b1, 1'b0, 1'b0);
    send_ev(OP_STOP, 1'b1, 1'b0, 1'b0);
    send_ev(OP_TICK, 1'b1, 1'b0, 1'b0);
    send_ev(OP_CLOSE_LIMIT, 1'b1, 1'b0, 1'b0);  // limit hit while idle
    send_ev(OP_CLOSE_CMD, 1'b1, 1'b0, 1'b0);
    send_ev(OP_CLOSE_LIMIT, 1'b1, 1'b0, 1'b1);
    send_ev(OP_TICK, 1'b0, 1'b1, 1'b1);
  endtask

  initial begin
    int mn, mx, lim;
    rst_n                     = 1'b0;
    cfg_we                    = 1'b0;
    cfg_idx                   = '0;
    cfg_data                  = '0;
    in_if.valid               = 1'b0;
    in_if.op                  = '0;
    in_if.level_ok            = 1'b0;
    in_if.open_limit_pressed  = 1'b0;
    in_if.close_limit_pressed = 1'b0;
    send_idle_pct             = 25;
    recv_idle_pct             = 63;
    hold_left                 = 0;
    live_requests             = 0;
    accepted                  = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed();
    run_phase(320);

    for (int p = 1; p < 6; p++) begin
      case (p)
        1: begin mn = 0;   mx = 0;   lim = 0;     end
        2: begin mn = 127; mx = 127; lim = 8;     end
        3: begin mn = 90;  mx = 10;  lim = 65535; end
        4: begin mn = 100; mx = 100; lim = 3;     end
        default: begin
          mn  = $urandom_range(127);
          mx  = $urandom_range(127);
          lim = $urandom_range(40);
        end
      endcase
      configure(mn, mx, lim);
      if (p == 2) begin
        send_idle_pct = 63;
        recv_idle_pct = 25;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_phase(320);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Run covered %0d requests over six register settings, %0d results checked,",
             accepted, sb.results_checked);
    $display("%0d of them timeout stops, with stalls on both channels.", sb.timeouts_due);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("PASS gate_motor_controller");
    end else begin
      $display("FAIL gate_motor_controller");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/gmc_pkg.sv
rtl/gmc_if.sv
rtl/gmc_core.sv
rtl/gate_motor_controller.sv
tb/sv/tb.sv
